### hdl/pswe_pkg.sv
// Shared types, codes and helper functions of the particle swarm update engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package pswe_pkg;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {
      REQ_BOUNDS = 2'd0,
      REQ_ELEM   = 2'd1,
      REQ_SCORE  = 2'd2,
      REQ_MOVE   = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INERTIA   = 3'd0,
      CSR_PGAIN     = 3'd1,
      CSR_GGAIN     = 3'd2,
      CSR_PARTICLES = 3'd3,
      CSR_DIMS      = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SC_CMP,
      ST_PB_COPY,
      ST_SC_LAST,
      ST_SB_COPY,
      ST_MV_M0,
      ST_MV_M1,
      ST_MV_M2,
      ST_MV_M3,
      ST_MV_SUM,
      ST_MV_POS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [15:0] inertia_weight;
      logic [15:0] personal_gain;
      logic [15:0] global_gain;
      logic [4:0]  particles_in_use;
      logic [3:0]  dims_in_use;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic set_err;
      logic wr_bounds;
      logic wr_elem;
      logic sc_update;
      logic copy_start;
      logic copy_run;
      logic clr_pending;
      logic mv_m0;
      logic mv_m1;
      logic mv_m2;
      logic mv_m3;
      logic mv_sum;
      logic mv_pos;
   } cmd_type;

   typedef struct packed {
      logic         err;
      req_kind_type kind;
      logic         better;
      logic         pending;
      logic         last;
      logic         copy_done;
   } status_type;

   // Clamp a configured count into 1 .. maxv.
   function automatic logic [8:0] eff_count(input logic [8:0] cfg, input logic [8:0] maxv);
      logic [8:0] r;
      if (cfg == 9'd0) begin
         r = 9'd1;
      end else if (cfg > maxv) begin
         r = maxv;
      end else begin
         r = cfg;
      end
      return r;
   endfunction

   // Saturate a signed sum to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [38:0] x);
      logic signed [31:0] r;
      if (x > 39'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -39'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

### hdl/pswe_ctrl.sv
// Sequencing state machine of the particle swarm update engine.
// Depends on pswe_pkg for the state, command and status types.
module pswe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                out_free,
   input  pswe_pkg::status_type status,
   output pswe_pkg::cmd_type   cmd,
   output logic                emit
);
   import pswe_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.err) begin
               state_in = ST_DONE;
            end else begin
               unique case (status.kind)
                  REQ_BOUNDS: state_in = ST_DONE;
                  REQ_ELEM:   state_in = ST_DONE;
                  REQ_SCORE:  state_in = ST_SC_CMP;
                  REQ_MOVE:   state_in = ST_MV_M0;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_SC_CMP:  state_in = status.better ? ST_PB_COPY : ST_SC_LAST;
         ST_PB_COPY: if (status.copy_done) state_in = ST_SC_LAST;
         ST_SC_LAST: state_in = (status.last && status.pending) ? ST_SB_COPY : ST_DONE;
         ST_SB_COPY: if (status.copy_done) state_in = ST_DONE;
         ST_MV_M0:   state_in = ST_MV_M1;
         ST_MV_M1:   state_in = ST_MV_M2;
         ST_MV_M2:   state_in = ST_MV_M3;
         ST_MV_M3:   state_in = ST_MV_SUM;
         ST_MV_SUM:  state_in = ST_MV_POS;
         ST_MV_POS:  state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      emit      = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CHECK: begin
            cmd.set_err   = status.err;
            cmd.wr_bounds = !status.err && (status.kind == REQ_BOUNDS);
            cmd.wr_elem   = !status.err && (status.kind == REQ_ELEM);
         end
         ST_SC_CMP: begin
            cmd.sc_update  = status.better;
            cmd.copy_start = status.better;
         end
         ST_PB_COPY: cmd.copy_run = 1'b1;
         ST_SC_LAST: cmd.copy_start = status.last && status.pending;
         ST_SB_COPY: begin
            cmd.copy_run    = 1'b1;
            cmd.clr_pending = status.copy_done;
         end
         ST_MV_M0:  cmd.mv_m0  = 1'b1;
         ST_MV_M1:  cmd.mv_m1  = 1'b1;
         ST_MV_M2:  cmd.mv_m2  = 1'b1;
         ST_MV_M3:  cmd.mv_m3  = 1'b1;
         ST_MV_SUM: cmd.mv_sum = 1'b1;
         ST_MV_POS: cmd.mv_pos = 1'b1;
         ST_DONE:   emit = out_free;
         default:   emit = 1'b0;
      endcase
   end

endmodule

### hdl/pswe_datapath.sv
// Datapath of the particle swarm update engine: state memories, best tracking,
// row copy engine and the fixed-point move arithmetic. Depends on pswe_pkg.
module pswe_datapath #(
   parameter int PARTICLE_COUNT = 16,
   parameter int NUM_DIMS       = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pswe_pkg::cfg_type                    cfg,
   input  pswe_pkg::cmd_type                    cmd,
   input  logic [pswe_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [1:0]                           req_tuser,
   input  logic                                 req_tlast,
   output pswe_pkg::status_type                 status,
   output logic signed [31:0]                   new_position,
   output logic signed [31:0]                   best_score,
   output logic [3:0]                           best_particle,
   output logic                                 best_valid,
   output logic                                 index_error
);
   import pswe_pkg::*;

   localparam int DEPTH = PARTICLE_COUNT * NUM_DIMS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
   localparam int DW    = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
   localparam int CW    = $clog2(NUM_DIMS + 1);

   // Captured request.
   req_kind_type       kind_ff;
   logic [3:0]         p_ff;
   logic [2:0]         d_ff;
   logic signed [31:0] va_ff, vb_ff;
   logic [15:0]        rp_ff, rg_ff;
   logic               last_ff;
   logic               err_ff;
   logic signed [31:0] newpos_ff;

   // Best tracking.
   logic signed [31:0] sbs_ff;
   logic [3:0]         holder_ff;
   logic               pending_ff;
   logic               seen_ff;

   // Memories.
   logic signed [31:0] pos_mem [DEPTH];
   logic signed [31:0] vel_mem [DEPTH];
   logic signed [31:0] ob_mem  [DEPTH];
   logic signed [31:0] obs_mem [PARTICLE_COUNT];
   logic signed [31:0] sbp_mem [NUM_DIMS];
   logic signed [31:0] lo_mem  [NUM_DIMS];
   logic signed [31:0] hi_mem  [NUM_DIMS];
   logic [PARTICLE_COUNT-1:0] obs_vld_ff;
   logic [NUM_DIMS-1:0]       sbp_vld_ff;

   logic signed [31:0] pos_rd_ff, vel_rd_ff, ob_rd_ff, obs_rd_ff;
   logic signed [31:0] sbp_rd_ff, lo_rd_ff, hi_rd_ff;
   logic               obs_rvld_ff, sbp_rvld_ff;

   // Copy engine.
   logic [CW-1:0] cnt_ff;
   logic          wvld_ff;
   logic [DW-1:0] widx_ff;
   logic          csel_ff;

   // Move arithmetic.
   logic [19:0]        cp_ff, cg_ff;
   logic signed [32:0] dp_ff, dg_ff;
   logic signed [35:0] tw_ff;
   logic signed [36:0] tp_ff, tg_ff;
   logic signed [31:0] nv_ff;

   logic [8:0]         np, nd;
   logic               perr, derr, err_c;
   logic [AW-1:0]      e_addr, pbase, hbase, pos_raddr, ob_raddr;
   logic [PW-1:0]      p_idx;
   logic [DW-1:0]      d_idx, cnt_lo;
   logic               cnt_more;
   logic signed [31:0] obs_cur;
   logic [31:0]        cp_full, cg_full;
   logic signed [47:0] tw_full;
   logic signed [53:0] tp_full, tg_full;
   logic signed [38:0] vsum;
   logic signed [32:0] xsum;
   logic signed [31:0] nx_sat, nx_lo, nx_c;

   always_comb begin
      np     = eff_count({4'd0, cfg.particles_in_use}, 9'(PARTICLE_COUNT));
      nd     = eff_count({5'd0, cfg.dims_in_use}, 9'(NUM_DIMS));
      perr   = {5'd0, p_ff} >= np;
      derr   = {6'd0, d_ff} >= nd;
      unique case (kind_ff)
         REQ_BOUNDS: err_c = derr;
         REQ_SCORE:  err_c = perr;
         default:    err_c = perr || derr;
      endcase
      p_idx    = PW'(p_ff);
      d_idx    = DW'(d_ff);
      e_addr   = AW'(32'(p_ff) * NUM_DIMS + 32'(d_ff));
      pbase    = AW'(32'(p_ff) * NUM_DIMS);
      hbase    = AW'(32'(holder_ff) * NUM_DIMS);
      cnt_lo   = cnt_ff[DW-1:0];
      cnt_more = cnt_ff < CW'(NUM_DIMS);
      pos_raddr = cmd.copy_run ? pbase + AW'(cnt_lo) : e_addr;
      ob_raddr  = cmd.copy_run ? hbase + AW'(cnt_lo) : e_addr;
      obs_cur   = obs_rvld_ff ? obs_rd_ff : SCORE_MAX;
   end

   assign status.err       = err_c;
   assign status.kind      = kind_ff;
   assign status.better    = va_ff < obs_cur;
   assign status.pending   = pending_ff;
   assign status.last      = last_ff;
   assign status.copy_done = !cnt_more && !wvld_ff;

   // Request capture and result fields.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind_type'(req_tuser);
         p_ff    <= req_tdata[3:0];
         d_ff    <= req_tdata[6:4];
         va_ff   <= req_tdata[38:7];
         vb_ff   <= req_tdata[70:39];
         rp_ff   <= req_tdata[86:71];
         rg_ff   <= req_tdata[102:87];
         last_ff <= req_tlast;
         err_ff  <= 1'b0;
         newpos_ff <= '0;
      end else begin
         if (cmd.set_err) err_ff <= 1'b1;
         if (cmd.mv_pos) newpos_ff <= nx_c;
      end
   end

   // Swarm best and personal best scores.
   always_ff @(posedge clock) begin
      if (reset) begin
         sbs_ff     <= SCORE_MAX;
         holder_ff  <= '0;
         pending_ff <= 1'b0;
         seen_ff    <= 1'b0;
         obs_vld_ff <= '0;
      end else begin
         if (cmd.sc_update) begin
            obs_vld_ff[p_idx] <= 1'b1;
            if (va_ff < sbs_ff) begin
               sbs_ff     <= va_ff;
               holder_ff  <= p_ff;
               pending_ff <= 1'b1;
               seen_ff    <= 1'b1;
            end
         end
         if (cmd.clr_pending) pending_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sc_update) obs_mem[p_idx] <= va_ff;
      obs_rd_ff   <= obs_mem[p_idx];
      obs_rvld_ff <= obs_vld_ff[p_idx];
   end

   // Row copy engine: one element read and one written per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         wvld_ff <= 1'b0;
         csel_ff <= 1'b0;
      end else if (cmd.copy_start) begin
         cnt_ff  <= '0;
         wvld_ff <= 1'b0;
         csel_ff <= cmd.sc_update ? 1'b0 : 1'b1;
      end else if (cmd.copy_run) begin
         wvld_ff <= cnt_more;
         if (cnt_more) cnt_ff <= cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy_run) widx_ff <= cnt_lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sbp_vld_ff <= '0;
      end else if (cmd.copy_run && wvld_ff && csel_ff) begin
         sbp_vld_ff[widx_ff] <= 1'b1;
      end
   end

   // Element stores.
   always_ff @(posedge clock) begin
      if (cmd.wr_elem) begin
         pos_mem[e_addr] <= va_ff;
         vel_mem[e_addr] <= vb_ff;
      end else if (cmd.mv_pos) begin
         pos_mem[e_addr] <= nx_c;
         vel_mem[e_addr] <= nv_ff;
      end
      pos_rd_ff <= pos_mem[pos_raddr];
      vel_rd_ff <= vel_mem[e_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_elem) begin
         ob_mem[e_addr] <= va_ff;
      end else if (cmd.copy_run && wvld_ff && !csel_ff) begin
         ob_mem[pbase + AW'(widx_ff)] <= pos_rd_ff;
      end
      ob_rd_ff <= ob_mem[ob_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.copy_run && wvld_ff && csel_ff) sbp_mem[widx_ff] <= ob_rd_ff;
      sbp_rd_ff   <= sbp_mem[d_idx];
      sbp_rvld_ff <= sbp_vld_ff[d_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_bounds) begin
         lo_mem[d_idx] <= va_ff;
         hi_mem[d_idx] <= vb_ff;
      end
      lo_rd_ff <= lo_mem[d_idx];
      hi_rd_ff <= hi_mem[d_idx];
   end

   // Move arithmetic, up to two products per step. The three terms can each
   // approach 2^35 or 2^36, so their sum needs 39 bits before saturation.
   always_comb begin
      cp_full = 32'(cfg.personal_gain) * 32'(rp_ff);
      cg_full = 32'(cfg.global_gain) * 32'(rg_ff);
      tw_full = 48'(vel_rd_ff) * $signed({32'd0, cfg.inertia_weight});
      tp_full = $signed({34'd0, cp_ff}) * 54'(dp_ff);
      tg_full = $signed({34'd0, cg_ff}) * 54'(dg_ff);
      vsum    = 39'(tw_ff) + 39'(tp_ff) + 39'(tg_ff);
      xsum    = 33'(pos_rd_ff) + 33'(nv_ff);
      nx_sat  = sat32(39'(xsum));
      nx_lo   = (nx_sat < lo_rd_ff) ? lo_rd_ff : nx_sat;
      nx_c    = (nx_lo > hi_rd_ff) ? hi_rd_ff : nx_lo;
   end

   always_ff @(posedge clock) begin
      if (cmd.mv_m0) begin
         cp_ff <= cp_full[31:12];
         cg_ff <= cg_full[31:12];
         dp_ff <= 33'(ob_rd_ff) - 33'(pos_rd_ff);
         dg_ff <= 33'(sbp_rvld_ff ? sbp_rd_ff : 32'sd0) - 33'(pos_rd_ff);
      end
      if (cmd.mv_m1)  tw_ff <= tw_full[47:12];
      if (cmd.mv_m2)  tp_ff <= tp_full[52:16];
      if (cmd.mv_m3)  tg_ff <= tg_full[52:16];
      if (cmd.mv_sum) nv_ff <= sat32(vsum);
   end

   assign new_position  = newpos_ff;
   assign best_score    = sbs_ff;
   assign best_particle = holder_ff;
   assign best_valid    = seen_ff;
   assign index_error   = err_ff;

endmodule

### hdl/particle_swarm_update_engine_unit.sv
// Top level of the particle swarm update engine: configuration registers,
// response register and the controller/datapath pair. Depends on pswe_pkg.
// A score request runs up to two row copies of NUM_DIMS elements each.
// One request at a time: the next is taken once the last result has entered the
// response register.
// Reset clears control state, best tracking and valid bits; no clearing pass is needed.
module particle_swarm_update_engine_unit #(
   parameter int PARTICLE_COUNT = 16,
   parameter int NUM_DIMS       = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel. tdata from bit 0: particle_index(4), dim_index(3),
   // value_a(32), value_b(32), rand_personal(16), rand_global(16), zero fill.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pswe_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser from bit 0: req_type(2).
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tlast,
   // Response channel. tdata from bit 0: new_position(32), best_score(32),
   // best_particle(4), best_valid(1), index_error(1), zero fill.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pswe_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Configuration write channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pswe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pswe_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pswe_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;
   logic       emit, out_free;
   logic       rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic signed [31:0] new_position, best_score;
   logic [3:0]         best_particle;
   logic               best_valid, index_error;

   // Configuration registers are written at any time the channel is valid; the user
   // must change them only while the engine is idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inertia_weight   <= 16'd2949;
         cfg_ff.personal_gain    <= 16'd6144;
         cfg_ff.global_gain      <= 16'd6144;
         cfg_ff.particles_in_use <= 5'd16;
         cfg_ff.dims_in_use      <= 4'd8;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INERTIA:   cfg_ff.inertia_weight   <= csr_data;
            CSR_PGAIN:     cfg_ff.personal_gain    <= csr_data;
            CSR_GGAIN:     cfg_ff.global_gain      <= csr_data;
            CSR_PARTICLES: cfg_ff.particles_in_use <= csr_data[4:0];
            CSR_DIMS:      cfg_ff.dims_in_use      <= csr_data[3:0];
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   // The response register frees as soon as the held response is taken, so the
   // engine can finish the next request in the same cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   pswe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd),
      .emit      (emit)
   );

   pswe_datapath #(
      .PARTICLE_COUNT (PARTICLE_COUNT),
      .NUM_DIMS       (NUM_DIMS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd           (cmd),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .status        (status),
      .new_position  (new_position),
      .best_score    (best_score),
      .best_particle (best_particle),
      .best_valid    (best_valid),
      .index_error   (index_error)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= {2'b00, index_error, best_valid, best_particle,
                         best_score, new_position};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // A request that has been accepted keeps the engine busy for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("engine accepted a request while busy");

   // A result is only loaded when the response register can take it.
   assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before it was taken");

   // Once recorded, a swarm best never disappears.
   assert property (@(posedge clock) disable iff (reset)
      !$fell(best_valid))
      else $error("swarm best lost");

   // An ignored request never reports a moved position.
   assert property (@(posedge clock) disable iff (reset)
      (emit && index_error) |-> (new_position == 32'sd0))
      else $error("ignored request reported a position");
`endif

endmodule

### dv/pswe_checker.sv
`timescale 1ns / 1ps
// Checker for the particle swarm update engine: watches the request, response and
// configuration channels, predicts every response and compares. Depends on pswe_pkg.
module pswe_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [pswe_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                      req_tuser,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [pswe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [pswe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pswe_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              mismatches,
   output int                              outstanding,
   output int                              responses_seen
);
   import pswe_pkg::*;

   typedef struct {
      logic signed [31:0] position;
      logic signed [31:0] score;
      logic [3:0]         holder;
      logic               valid;
      logic               err;
   } swarm_rsp_type;

   swarm_rsp_type pending_rsp[$];

   logic [15:0] inertia_q, pgain_q, ggain_q;
   logic [4:0]  particles_q;
   logic [3:0]  dims_q;

   logic signed [31:0] pos_m[128], vel_m[128], own_pos_m[128];
   logic signed [31:0] own_score_m[16];
   logic signed [31:0] swarm_pos_m[8];
   logic signed [31:0] lower_m[8], upper_m[8];
   logic signed [31:0] swarm_score_m;
   logic [3:0]         swarm_holder_m;
   logic               copy_due_m, seen_m;

   function automatic logic signed [31:0] clip32(input longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   task automatic clear_swarm();
      inertia_q = 16'd2949;
      pgain_q = 16'd6144;
      ggain_q = 16'd6144;
      particles_q = 5'd16;
      dims_q = 4'd8;
      for (int i = 0; i < 128; i++) begin
         pos_m[i] = '0;
         vel_m[i] = '0;
         own_pos_m[i] = '0;
      end
      for (int i = 0; i < 16; i++) own_score_m[i] = SCORE_MAX;
      for (int i = 0; i < 8; i++) begin
         swarm_pos_m[i] = '0;
         lower_m[i] = '0;
         upper_m[i] = '0;
      end
      swarm_score_m = SCORE_MAX;
      swarm_holder_m = '0;
      copy_due_m = 1'b0;
      seen_m = 1'b0;
   endtask

   // Applies one request to the shadow state and queues the response it must produce.
   task automatic predict_swarm_update(input logic [REQ_DATA_W-1:0] d_in,
                                       input req_kind_type kind, input logic last);
      logic [3:0] p;
      logic [2:0] d;
      logic signed [31:0] va, vb, nv, nx;
      longint x, v, cp, cg, tw, tp, tg;
      int np, nd, e;
      logic perr, derr, err;
      swarm_rsp_type r;
      p = d_in[3:0];
      d = d_in[6:4];
      va = d_in[38:7];
      vb = d_in[70:39];
      np = (particles_q == 0) ? 1 : (particles_q > 16) ? 16 : particles_q;
      nd = (dims_q == 0) ? 1 : (dims_q > 8) ? 8 : dims_q;
      perr = p >= np;
      derr = d >= nd;
      e = p * 8 + d;
      r.position = '0;
      case (kind)
         REQ_BOUNDS: begin
            err = derr;
            if (!err) begin
               lower_m[d] = va;
               upper_m[d] = vb;
            end
         end
         REQ_ELEM: begin
            err = perr || derr;
            if (!err) begin
               pos_m[e] = va;
               vel_m[e] = vb;
               own_pos_m[e] = va;
            end
         end
         REQ_SCORE: begin
            err = perr;
            if (!err) begin
               if (va < own_score_m[p]) begin
                  own_score_m[p] = va;
                  for (int i = 0; i < 8; i++) own_pos_m[p*8+i] = pos_m[p*8+i];
                  if (va < swarm_score_m) begin
                     swarm_score_m = va;
                     swarm_holder_m = p;
                     copy_due_m = 1'b1;
                     seen_m = 1'b1;
                  end
               end
               if (last && copy_due_m) begin
                  for (int i = 0; i < 8; i++) swarm_pos_m[i] = own_pos_m[swarm_holder_m*8+i];
                  copy_due_m = 1'b0;
               end
            end
         end
         default: begin
            err = perr || derr;
            if (!err) begin
               x = pos_m[e];
               v = vel_m[e];
               cp = (longint'(pgain_q) * longint'(d_in[86:71])) >>> 12;
               cg = (longint'(ggain_q) * longint'(d_in[102:87])) >>> 12;
               tw = (v * longint'(inertia_q)) >>> 12;
               tp = (cp * (longint'(own_pos_m[e]) - x)) >>> 16;
               tg = (cg * (longint'(swarm_pos_m[d]) - x)) >>> 16;
               nv = clip32(tw + tp + tg);
               nx = clip32(x + longint'(nv));
               if (nx < lower_m[d]) nx = lower_m[d];
               if (nx > upper_m[d]) nx = upper_m[d];
               vel_m[e] = nv;
               pos_m[e] = nx;
               r.position = nx;
            end
         end
      endcase
      r.score = swarm_score_m;
      r.holder = swarm_holder_m;
      r.valid = seen_m;
      r.err = err;
      pending_rsp.push_back(r);
   endtask

   always @(posedge clock) begin
      swarm_rsp_type want;
      if (reset) begin
         clear_swarm();
         pending_rsp.delete();
         mismatches <= 0;
         responses_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_INERTIA:   inertia_q = csr_data;
               CSR_PGAIN:     pgain_q = csr_data;
               CSR_GGAIN:     ggain_q = csr_data;
               CSR_PARTICLES: particles_q = csr_data[4:0];
               CSR_DIMS:      dims_q = csr_data[3:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            responses_seen <= responses_seen + 1;
            if (pending_rsp.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("%0t: response with none expected: %h",
                                             $realtime, rsp_tdata);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_tdata[31:0] !== want.position || rsp_tdata[63:32] !== want.score ||
                   rsp_tdata[67:64] !== want.holder || rsp_tdata[68] !== want.valid ||
                   rsp_tdata[69] !== want.err) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("%0t: mismatch exp pos %h score %h holder %0d valid %b err %b, got pos %h score %h holder %0d valid %b err %b",
                              $realtime, want.position, want.score, want.holder, want.valid,
                              want.err, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[67:64],
                              rsp_tdata[68], rsp_tdata[69]);
               end
            end
         end
         // Prediction follows the pop so a same-edge request never meets its own result.
         if (req_tvalid && req_tready)
            predict_swarm_update(req_tdata, req_kind_type'(req_tuser), req_tlast);
      end
      outstanding <= pending_rsp.size();
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Top of the particle swarm engine testbench: clock, reset, request and register
// stimulus, and the verdict. Depends on pswe_pkg, pswe_checker and the engine itself.
module testbench;
   import pswe_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tready = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   wire req_tready, rsp_tvalid, csr_ready;
   wire [RSP_DATA_W-1:0] rsp_tdata;
   int mismatches, outstanding, responses_seen;

   // When set, neither the request sender nor the response taker idles.
   bit steady = 1'b0;
   int requests_sent = 0;
   int sweeps_run = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   particle_swarm_update_engine_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   pswe_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatches(mismatches), .outstanding(outstanding), .responses_seen(responses_seen)
   );

   // The response side stalls at random, about 12 percent of the time, unless steady is set.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 12);
   end

   // Sends one request. Ready is sampled at the falling edge, where the engine's
   // registered output is settled, and the transfer then happens on the next rise.
   task automatic send_request(input req_kind_type kind, input logic [3:0] p,
                               input logic [2:0] d, input logic [31:0] va,
                               input logic [31:0] vb, input logic [15:0] rp,
                               input logic [15:0] rg, input logic last);
      if (!steady && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tlast <= last;
      req_tdata <= {1'b0, rg, rp, vb, va, d, p};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      requests_sent++;
   endtask

   task automatic release_request();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every predicted response has been taken, then idles before returning.
   task automatic drain();
      release_request();
      while (outstanding != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] w, input logic [15:0] gp,
                             input logic [15:0] gg, input logic [4:0] np,
                             input logic [3:0] nd);
      drain();
      write_register(CSR_INERTIA, w);
      write_register(CSR_PGAIN, gp);
      write_register(CSR_GGAIN, gg);
      write_register(CSR_PARTICLES, {11'd0, np});
      write_register(CSR_DIMS, {12'd0, nd});
   endtask

   function automatic logic [31:0] any_word();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom) >>> $urandom_range(8, 30));
         default: return $urandom;
      endcase
   endfunction

   // A full sweep scores particles in order and marks the last one.
   task automatic score_sweep(input int count);
      logic [31:0] s;
      for (int i = 0; i < count; i++) begin
         s = ($urandom_range(9) == 0) ? any_word()
                                     : 32'($signed($urandom) >>> $urandom_range(0, 31));
         send_request(REQ_SCORE, i[3:0], 3'($urandom), s, $urandom, 16'($urandom),
                      16'($urandom), i == count - 1);
      end
      sweeps_run++;
   endtask

   task automatic random_request();
      logic [31:0] lo, hi;
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         lo = 32'($signed($urandom) >>> $urandom_range(1, 8));
         hi = (pick == 0) ? lo - 32'd5 : lo + ($urandom >> $urandom_range(1, 8));
         if (hi[31] != lo[31] && !hi[31] && lo[31]) hi = hi; // wide span is fine
         if ($signed(hi) < $signed(lo) && pick != 0) hi = 32'h7FFF_FFFF;
         send_request(REQ_BOUNDS, 4'($urandom), 3'($urandom), lo, hi, 16'($urandom),
                      16'($urandom), 1'($urandom));
      end else if (pick < 18) begin
         send_request(REQ_ELEM, 4'($urandom), 3'($urandom), any_word(), any_word(),
                      16'($urandom), 16'($urandom), 1'($urandom));
      end else if (pick < 30) begin
         score_sweep($urandom_range(1, 16));
      end else if (pick < 34) begin
         send_request(REQ_SCORE, 4'($urandom), 3'($urandom), $urandom, $urandom,
                      16'($urandom), 16'($urandom), 1'($urandom));
      end else begin
         send_request(REQ_MOVE, 4'($urandom), 3'($urandom), $urandom, $urandom,
                      16'($urandom), 16'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every bound and every element first so that no later read hits an
      // entry that was never written, even through the swarm-best copy.
      steady = 1'b1;
      for (int d = 0; d < 8; d++)
         send_request(REQ_BOUNDS, 4'($urandom), d[2:0],
                      32'hC000_0000 + $urandom_range(0, 4095),
                      32'h4000_0000 - $urandom_range(0, 4095), 16'($urandom),
                      16'($urandom), 1'b0);
      steady = 1'b0;
      for (int p = 0; p < 16; p++)
         for (int d = 0; d < 8; d++)
            send_request(REQ_ELEM, p[3:0], d[2:0], 32'($signed($urandom) >>> 4),
                         32'($signed($urandom) >>> 6), 16'($urandom), 16'($urandom),
                         1'b0);

      // Directed: inverted bounds, saturating moves, ties and sweep ends.
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd16, 4'd8);
      send_request(REQ_BOUNDS, 4'd0, 3'd0, 32'd100, -32'sd100, 16'd0, 16'd0, 1'b0);
      send_request(REQ_ELEM, 4'd0, 3'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 16'd0, 1'b0);
      send_request(REQ_MOVE, 4'd0, 3'd0, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 1'b0);
      send_request(REQ_BOUNDS, 4'd0, 3'd1, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 16'd0, 1'b0);
      send_request(REQ_ELEM, 4'd1, 3'd1, 32'h8000_0000, 32'h8000_0000, 16'd0, 16'd0, 1'b0);
      send_request(REQ_MOVE, 4'd1, 3'd1, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 1'b0);
      send_request(REQ_SCORE, 4'd0, 3'd0, 32'h7FFF_FFFF, 32'd0, 16'd0, 16'd0, 1'b0);
      send_request(REQ_SCORE, 4'd1, 3'd0, 32'h8000_0000, 32'd0, 16'd0, 16'd0, 1'b1);
      send_request(REQ_SCORE, 4'd2, 3'd0, 32'h8000_0000, 32'd0, 16'd0, 16'd0, 1'b0);
      send_request(REQ_SCORE, 4'd15, 3'd0, 32'd5, 32'd0, 16'd0, 16'd0, 1'b1);
      send_request(REQ_MOVE, 4'd15, 3'd7, 32'd0, 32'd0, 16'h8000, 16'h0001, 1'b0);
      set_config(16'd0, 16'd0, 16'd0, 5'd0, 4'd0);
      send_request(REQ_SCORE, 4'd1, 3'd0, 32'd1, 32'd0, 16'd0, 16'd0, 1'b1);
      send_request(REQ_MOVE, 4'd0, 3'd1, 32'd0, 32'd0, 16'd1, 16'd1, 1'b0);
      send_request(REQ_BOUNDS, 4'd0, 3'd3, 32'd0, 32'd1, 16'd0, 16'd0, 1'b0);
      send_request(REQ_ELEM, 4'd15, 3'd0, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0);
      send_request(REQ_MOVE, 4'd0, 3'd0, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 1'b0);
      set_config(16'd4096, 16'd8192, 16'd8192, 5'd31, 4'd15);
      send_request(REQ_MOVE, 4'd15, 3'd7, 32'd0, 32'd0, 16'hFFFF, 16'h0000, 1'b0);
      send_request(REQ_SCORE, 4'd15, 3'd0, 32'h8000_0000, 32'd0, 16'd0, 16'd0, 1'b1);

      // Random phases, each under its own register setting; a long steady
      // stretch in the second phase, and an extra full drain within the fourth phase.
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) set_config(16'd2949, 16'd6144, 16'd6144, 5'd16, 4'd8);
         else set_config(16'($urandom),
                         ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
                         16'($urandom),
                         ($urandom_range(3) == 0) ? 5'($urandom) : 5'd16,
                         ($urandom_range(3) == 0) ? 4'($urandom) : 4'd8);
         steady = (phase == 1);
         for (int n = 0; n < 110; n++) begin
            random_request();
            if (phase == 3 && n == 60) drain();
         end
      end
      steady = 1'b0;
      drain();

      $display("Run covered %0d requests (%0d responses) over %0d scoring sweeps,",
               requests_sent, responses_seen, sweeps_run);
      $display("with bound, element, move and score requests under nine register settings.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout after %0d requests.", requests_sent);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
hdl/pswe_pkg.sv
hdl/pswe_ctrl.sv
hdl/pswe_datapath.sv
hdl/particle_swarm_update_engine_unit.sv
dv/pswe_checker.sv
dv/testbench.sv
